// ===== hw/rtl/ivt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ivt_pkg;

  // default table geometry
  localparam int IVT_DEPTH     = 64;
  localparam int IVT_ITEM_BITS = 32;

  // command codes
  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_GET    = 3'd4;
  localparam logic [2:0] ACT_SET    = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  position;
    logic [31:0] item_data;
  } ivt_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [6:0]  count;
  } ivt_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ivt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ivt_mem #(
  parameter int DEPTH     = ivt_pkg::IVT_DEPTH,
  parameter int ITEM_BITS = ivt_pkg::IVT_ITEM_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [ITEM_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [ITEM_BITS-1:0] rd_data
);

  logic [ITEM_BITS-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ivt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ivt_ctrl #(
  parameter int DEPTH     = ivt_pkg::IVT_DEPTH,
  parameter int ITEM_BITS = ivt_pkg::IVT_ITEM_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ivt_pkg::ivt_in_t     in_data,
  output logic                 res_valid,
  output ivt_pkg::ivt_out_t    res,
  input  logic                 res_take,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [ITEM_BITS-1:0] mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [ITEM_BITS-1:0] mem_rd_data
);

  import ivt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW + 1 : 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_RDWAIT,
    S_RESULT
  } state_t;

  state_t               state;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        src;
  logic [AW-1:0]        last;
  logic                 shift_up;
  logic                 more;
  logic                 pend;
  logic [AW-1:0]        pend_dst;
  logic [AW-1:0]        hold_pos;
  logic [ITEM_BITS-1:0] hold_data;
  logic [31:0]          res_data;
  logic [1:0]           res_status;

  logic                 accept;
  logic                 full;
  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        n_w;
  logic [ITEM_BITS-1:0] wdata;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign full     = (cnt == CW'(DEPTH));
  assign pos_w    = PW'(in_data.position);
  assign n_w      = PW'(cnt);
  assign wdata    = ITEM_BITS'(in_data.item_data);

  assign res_valid = (state == S_RESULT);
  assign res       = '{read_data: res_data, status: res_status, count: 7'(cnt)};

  // memory port control
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_PUSH: begin
              if (!full) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(cnt);
                mem_wr_data = wdata;
              end
            end
            ACT_POP: begin
              if (cnt != '0) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(cnt - CW'(1));
              end
            end
            ACT_INSERT: begin
              // insert at the end needs no shift
              if (!full && (pos_w == n_w)) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(in_data.position);
                mem_wr_data = wdata;
              end
            end
            ACT_GET: begin
              if (pos_w < n_w) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_data.position);
              end
            end
            ACT_SET: begin
              if (pos_w < n_w) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(in_data.position);
                mem_wr_data = wdata;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (pend) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pend_dst;
          mem_wr_data = mem_rd_data;
        end
        if (more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = src;
        end
        // shift done: drop the new entry into the gap
        if (!more && !pend && shift_up) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = hold_pos;
          mem_wr_data = hold_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      more  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_data   <= '0;
            res_status <= ST_OK;
            hold_pos   <= AW'(in_data.position);
            hold_data  <= wdata;
            state      <= S_RESULT;
            case (in_data.action)
              ACT_PUSH: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
              ACT_POP: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  cnt   <= cnt - CW'(1);
                  state <= S_RDWAIT;
                end
              end
              ACT_INSERT: begin
                if (pos_w > n_w) begin
                  res_status <= ST_RANGE;
                end else if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                  if (pos_w != n_w) begin
                    state    <= S_SHIFT;
                    shift_up <= 1'b1;
                    src      <= AW'(cnt - CW'(1));
                    last     <= AW'(in_data.position);
                    more     <= 1'b1;
                    pend     <= 1'b0;
                  end
                end
              end
              ACT_REMOVE: begin
                if (pos_w >= n_w) begin
                  res_status <= ST_RANGE;
                end else begin
                  cnt <= cnt - CW'(1);
                  if ((pos_w + PW'(1)) != n_w) begin
                    state    <= S_SHIFT;
                    shift_up <= 1'b0;
                    src      <= AW'(pos_w + PW'(1));
                    last     <= AW'(cnt - CW'(1));
                    more     <= 1'b1;
                    pend     <= 1'b0;
                  end
                end
              end
              ACT_GET: begin
                if (pos_w >= n_w) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= S_RDWAIT;
                end
              end
              ACT_SET: begin
                if (pos_w >= n_w) begin
                  res_status <= ST_RANGE;
                end
              end
              default: begin
                res_status <= ST_RANGE;
              end
            endcase
          end
        end
        S_SHIFT: begin
          // read one entry per cycle, write it back one slot over in the next cycle
          if (more) begin
            pend     <= 1'b1;
            pend_dst <= shift_up ? AW'(src + AW'(1)) : AW'(src - AW'(1));
            if (src == last) begin
              more <= 1'b0;
            end else begin
              src <= shift_up ? AW'(src - AW'(1)) : AW'(src + AW'(1));
            end
          end else begin
            pend <= 1'b0;
          end
          if (!more && !pend) begin
            state <= S_RESULT;
          end
        end
        S_RDWAIT: begin
          res_data <= 32'(mem_rd_data);
          state    <= S_RESULT;
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_vector_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                        payload
// -------   ----------------------------   -------------------------------
// in        in_valid, in_stall, in_data    action, position, item_data
// out       out_valid, out_stall, out_data read_data, status, count
//
// push, set and refused commands go from accept straight to the result state;
// pop and get pass through a read-wait state first; insert and remove that move
// entries pass through the shift state, which moves one entry a cycle through
// the single read and write ports of the table memory.
// reset clears the entry count and the handshake state; table contents stay
// undefined and are never read before written, so there is no clearing pass.
// out_stall holds the output register; the next transaction is accepted while
// a result waits there.

module indexed_vector_table_top #(
  parameter int DEPTH     = ivt_pkg::IVT_DEPTH,
  parameter int ITEM_BITS = ivt_pkg::IVT_ITEM_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ivt_pkg::ivt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ivt_pkg::ivt_out_t out_data
);

  import ivt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer to output register
  logic     res_valid;
  logic     res_take;
  ivt_out_t res;

  // table memory ports
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [ITEM_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [ITEM_BITS-1:0] mem_rd_data;

  // result moves into the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid || !out_stall);

  ivt_ctrl #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ivt_mem #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register, one transaction deep
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ivt_pkg::*;

  localparam int DEPTH       = IVT_DEPTH;
  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction on either channel
  localparam int LONG_HOLD   = 300;   // receiver hold-off used to back up the block
  localparam int BLOCK_ITEMS = 50;

  // codes outside the six commands, which the block must refuse
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // growth shares for the random mix
  localparam int MIX_FILL  = 85;
  localparam int MIX_CHURN = 35;
  localparam int MIX_DRAIN = 10;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ivt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ivt_out_t out_data;

  indexed_vector_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table contents and fill level
  logic [31:0] shadow_mem [DEPTH];
  int          shadow_len = 0;

  ivt_out_t results_due [$];
  int       err_count     = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_reqs     = 0;

  typedef struct {
    ivt_in_t  cmd;
    bit       typed;
    ivt_out_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic ivt_in_t cmd_of(input logic [2:0] act, input int pos,
                                     input logic [31:0] data);
    ivt_in_t c;
    c.action    = act;
    c.position  = pos[6:0];
    c.item_data = data;
    return c;
  endfunction

  function automatic ivt_out_t res_of(input logic [31:0] rd, input logic [1:0] st,
                                      input int cnt);
    ivt_out_t r;
    r.read_data = rd;
    r.status    = st;
    r.count     = cnt[6:0];
    return r;
  endfunction

  // apply one command to the shadow table and return what the block should answer
  function automatic ivt_out_t table_apply(input ivt_in_t cmd);
    ivt_out_t r;
    int       p;
    int       i;
    r.read_data = '0;
    r.status    = ST_OK;
    p = int'(cmd.position);
    case (cmd.action)
      ACT_PUSH: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[shadow_len] = cmd.item_data;
          shadow_len++;
        end
      end
      ACT_POP: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_len--;
          r.read_data = shadow_mem[shadow_len];
        end
      end
      ACT_INSERT: begin
        // position is checked before fullness
        if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_mem[i] = shadow_mem[i - 1];
          shadow_mem[p] = cmd.item_data;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i + 1];
          shadow_len--;
        end
      end
      ACT_GET: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.read_data = shadow_mem[p];
      end
      ACT_SET: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else shadow_mem[p] = cmd.item_data;
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = shadow_len[6:0];
    return r;
  endfunction

  // random command; growth share steers the fill level, positions mostly in range
  function automatic ivt_in_t random_cmd(input int grow_pct);
    ivt_in_t c;
    int      hi;
    c.item_data = $urandom();
    if ($urandom_range(99) < 3) begin
      c.action = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    end else if ($urandom_range(99) < grow_pct) begin
      c.action = $urandom_range(1) ? ACT_INSERT : ACT_PUSH;
    end else begin
      case ($urandom_range(3))
        0:       c.action = ACT_POP;
        1:       c.action = ACT_REMOVE;
        2:       c.action = ACT_GET;
        default: c.action = ACT_SET;
      endcase
    end
    if (c.action == ACT_INSERT) hi = shadow_len;
    else hi = (shadow_len > 0) ? shadow_len - 1 : 0;
    if ($urandom_range(99) < 15) c.position = 7'($urandom_range(127));
    else c.position = 7'($urandom_range(hi));
    return c;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic add_row(input logic [2:0] act, input int pos, input logic [31:0] data,
                         input bit typed, input logic [31:0] rd, input logic [1:0] st,
                         input int cnt);
    stim_row_t row;
    row.cmd   = cmd_of(act, pos, data);
    row.typed = typed;
    row.want  = res_of(rd, st, cnt);
    directed_rows.push_back(row);
  endtask

  // offer one transaction; valid stays high across back-to-back items
  task automatic offer(input ivt_in_t cmd, input bit typed, input ivt_out_t want);
    ivt_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge; the shadow table always moves, typed rows override
    predicted = table_apply(cmd);
    results_due.push_back(typed ? want : predicted);
  endtask

  task automatic send_random(input int n);
    int k;
    int mix;
    mix = MIX_CHURN;
    for (k = 0; k < n; k++) begin
      if (k % BLOCK_ITEMS == 0) begin
        case ($urandom_range(2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_CHURN;
          default: mix = MIX_DRAIN;
        endcase
      end
      offer(random_cmd(mix), 1'b0, '0);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int holds_served;
    holds_served = 0;
    forever begin
      if (hold_reqs != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  ivt_out_t oldest_result;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        note_error($sformatf("unexpected result rd=%h st=%0d cnt=%0d",
                             out_data.read_data, out_data.status, out_data.count));
      end else begin
        oldest_result = results_due.pop_front();
        if (out_data.read_data !== oldest_result.read_data)
          note_error($sformatf("read_data want %h got %h",
                               oldest_result.read_data, out_data.read_data));
        if (out_data.status !== oldest_result.status)
          note_error($sformatf("status want %0d got %0d",
                               oldest_result.status, out_data.status));
        if (out_data.count !== oldest_result.count)
          note_error($sformatf("count want %0d got %0d",
                               oldest_result.count, out_data.count));
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // empty-table refusals and spare codes
    add_row(ACT_POP,      0,   32'h0,        1'b1, 32'h0, ST_EMPTY, 0);
    add_row(ACT_GET,      0,   32'h0,        1'b1, 32'h0, ST_RANGE, 0);
    add_row(ACT_REMOVE,   0,   32'h0,        1'b1, 32'h0, ST_RANGE, 0);
    add_row(ACT_SET,      0,   32'h12345678, 1'b1, 32'h0, ST_RANGE, 0);
    add_row(ACT_INSERT,   1,   32'h0,        1'b1, 32'h0, ST_RANGE, 0);
    add_row(ACT_SPARE_LO, 0,   32'h0,        1'b1, 32'h0, ST_RANGE, 0);
    add_row(ACT_SPARE_HI, 127, 32'hFFFFFFFF, 1'b1, 32'h0, ST_RANGE, 0);
    // data extremes
    add_row(ACT_PUSH,     0,   32'hFFFFFFFF, 1'b1, 32'h0, ST_OK,    1);
    add_row(ACT_PUSH,     127, 32'h0,        1'b1, 32'h0, ST_OK,    2);
    // insert at front and at the count, then reads, writes and removals
    add_row(ACT_INSERT,   0,   32'hA5A5A5A5, 1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_INSERT,   3,   32'h5A5A5A5A, 1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_GET,      0,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_GET,      3,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_SET,      1,   32'hDEADBEEF, 1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_GET,      1,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_REMOVE,   1,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_REMOVE,   2,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    // out of range with entries held, then pops down to an empty-table refusal
    add_row(ACT_GET,      127, 32'h0,        1'b1, 32'h0, ST_RANGE, 2);
    add_row(ACT_INSERT,   64,  32'h0,        1'b1, 32'h0, ST_RANGE, 2);
    add_row(ACT_SPARE_LO, 1,   32'h0,        1'b1, 32'h0, ST_RANGE, 2);
    add_row(ACT_POP,      0,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_POP,      0,   32'h0,        1'b0, 32'h0, ST_OK,    0);
    add_row(ACT_POP,      0,   32'h0,        1'b1, 32'h0, ST_EMPTY, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sender rarely idles, receiver mostly stalled
    send_idle_pct  = 13;
    recv_stall_pct = 85;
    foreach (directed_rows[i])
      offer(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // fill to the brim, then the full-table cases and the longest shifts
    while (shadow_len < DEPTH) offer(cmd_of(ACT_PUSH, 0, $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_PUSH,   0,  $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_INSERT, 0,  $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_INSERT, 64, $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_INSERT, 65, $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_GET,    63, 32'h0),      1'b0, '0);
    offer(cmd_of(ACT_SET,    63, $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_REMOVE, 0,  32'h0),      1'b0, '0);
    offer(cmd_of(ACT_INSERT, 0,  $urandom()), 1'b0, '0);
    offer(cmd_of(ACT_REMOVE, 63, 32'h0),      1'b0, '0);
    offer(cmd_of(ACT_GET,    0,  32'h0),      1'b0, '0);
    send_random(170);

    // sender mostly idle, receiver rarely stalls
    send_idle_pct  = 85;
    recv_stall_pct = 13;
    send_random(170);

    // drain fully before the last phase
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);

    // no idling; the receiver holds off so the block backs up and stalls input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs <= hold_reqs + 1;
    send_random(170);
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (results_due.size() != 0)
      note_error($sformatf("%0d results never arrived", results_due.size()));

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== indexed_vector_table_top.f =====
hw/rtl/ivt_pkg.sv
hw/rtl/ivt_mem.sv
hw/rtl/ivt_ctrl.sv
hw/rtl/indexed_vector_table_top.sv
test/tb.sv
